FILE: rtl/tsb_pkg.sv
`default_nettype none
package tsb_pkg;

  localparam int COORD_W   = 20;
  localparam int TADDR_W   = 12;
  localparam int CH_W      = 8;
  localparam int TEXEL_W   = 3 * CH_W;
  localparam int CFG_IDX_W = 2;
  localparam int CFG_DAT_W = 7;

  localparam logic [CFG_IDX_W-1:0] CFG_TEX_WIDTH   = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_TEX_HEIGHT  = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_FILTER_MODE = 2'd2;

  localparam logic ACT_WRITE  = 1'b0;
  localparam logic ACT_SAMPLE = 1'b1;

  localparam logic MODE_NEAREST  = 1'b0;
  localparam logic MODE_BILINEAR = 1'b1;

  typedef struct packed {
    logic                       action;
    logic [TADDR_W-1:0]         texel_address;
    logic [CH_W-1:0]            in_red;
    logic [CH_W-1:0]            in_green;
    logic [CH_W-1:0]            in_blue;
    logic signed [COORD_W-1:0]  coord_u;
    logic signed [COORD_W-1:0]  coord_v;
  } in_t;

  typedef struct packed {
    logic [CH_W-1:0] out_red;
    logic [CH_W-1:0] out_green;
    logic [CH_W-1:0] out_blue;
  } out_t;

  typedef struct packed {
    logic [CFG_IDX_W-1:0] index;
    logic [CFG_DAT_W-1:0] data;
  } cfg_t;

endpackage
`default_nettype wire

FILE: rtl/tsb_if.sv
`default_nettype none
interface tsb_in_if;
  import tsb_pkg::*;
  logic valid;
  logic ready;
  in_t  data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

interface tsb_out_if;
  import tsb_pkg::*;
  logic valid;
  logic ready;
  out_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

interface tsb_cfg_if;
  import tsb_pkg::*;
  logic                 valid;
  logic                 ready;
  logic [CFG_IDX_W-1:0] index;
  logic [CFG_DAT_W-1:0] data;
  modport source (output valid, output index, output data, input ready);
  modport sink (input valid, input index, input data, output ready);
endinterface
`default_nettype wire

FILE: rtl/tsb_addr.sv
`default_nettype none
module tsb_addr #(
  parameter int MAX_SIDE        = 64,
  parameter int COORD_FRAC_BITS = 16,
  parameter int SZ_W            = $clog2(MAX_SIDE + 1),
  parameter int ADDR_W          = $clog2(MAX_SIDE * MAX_SIDE),
  parameter int WW              = 2 * COORD_FRAC_BITS + 1
) (
  input  wire                                 clk_i,
  input  wire                                 rst_ni,
  input  wire  [SZ_W-1:0]                     width_i,
  input  wire  [SZ_W-1:0]                     height_i,
  input  wire                                 mode_i,
  input  wire                                 in_valid_i,
  output logic                                in_ready_o,
  input  tsb_pkg::in_t                        in_data_i,
  output logic                                out_valid_o,
  input  wire                                 out_ready_i,
  output logic                                act_o,
  output logic [tsb_pkg::TADDR_W-1:0]         waddr_o,
  output logic [tsb_pkg::TEXEL_W-1:0]         wdata_o,
  output logic [3:0][ADDR_W-1:0]              rd_addr_o,
  output logic [3:0][WW-1:0]                  weight_o
);
  import tsb_pkg::*;

  localparam int F      = COORD_FRAC_BITS;
  localparam int SIDE_W = (MAX_SIDE > 1) ? $clog2(MAX_SIDE) : 1;
  localparam int CU_W   = F + 1;
  localparam int PU_W   = CU_W + SZ_W;
  localparam int AP_W   = SIDE_W + SZ_W + 1;
  localparam int PW     = 2 * CU_W;
  localparam int ONE_I  = 1 << F;
  localparam int HALF_I = 1 << (F - 1);
  localparam int AX_W   = 2 * SIDE_W + F;
  localparam logic [WW+1:0] W_ONE = (WW + 2)'(1) << (2 * F);

  logic en1, en2, en3, en4;
  logic v1_q, v2_q, v3_q, v4_q;

  // write payload rides along every stage
  logic                act1_q, act2_q, act3_q, act4_q;
  logic [TADDR_W-1:0]  wa1_q, wa2_q, wa3_q, wa4_q;
  logic [TEXEL_W-1:0]  wd1_q, wd2_q, wd3_q, wd4_q;

  logic [CU_W-1:0]     u_d, v_d, u1_q, v1c_q;
  logic [PU_W-1:0]     pu2_q, pv2_q;
  logic [AX_W-1:0]     ax_d, ay_d;
  logic [SIDE_W-1:0]   x0_q, x1_q, y0_q, y1_q;
  logic [F-1:0]        fx_q, fy_q;
  logic [CU_W-1:0]     gx, gy, fxe, fye;
  logic [3:0][ADDR_W-1:0] a_q;
  logic [3:0][WW-1:0]     w_q;

  assign en4 = !v4_q || out_ready_i;
  assign en3 = !v3_q || en4;
  assign en2 = !v2_q || en3;
  assign en1 = !v1_q || en2;
  assign in_ready_o = en1;

  always_comb begin
    if (in_data_i.coord_u < 0) u_d = '0;
    else if (32'(in_data_i.coord_u) > ONE_I) u_d = CU_W'(ONE_I);
    else u_d = CU_W'(in_data_i.coord_u);
    // row runs along 1-v
    if (in_data_i.coord_v < 0) v_d = CU_W'(ONE_I);
    else if (32'(in_data_i.coord_v) > ONE_I) v_d = '0;
    else v_d = CU_W'(ONE_I - int'(in_data_i.coord_v));
  end

  function automatic logic [AX_W-1:0] axis_f(input logic [PU_W-1:0] p,
                                             input logic [SZ_W-1:0] n,
                                             input logic bil);
    logic [PU_W-1:0]   d;
    logic [PU_W-1:0]   hi;
    logic [PU_W-1:0]   nm1;
    logic [SIDE_W-1:0] i0;
    logic [SIDE_W-1:0] i1;
    logic [F-1:0]      fr;
    nm1 = PU_W'(SZ_W'(n - 1'b1));
    hi  = nm1 << F;
    if (bil) begin
      // texel centres at half offsets, clamped to edge centres
      if (p < PU_W'(HALF_I)) d = '0;
      else d = p - PU_W'(HALF_I);
      if (d > hi) d = hi;
      i0 = SIDE_W'(d >> F);
      fr = d[F-1:0];
      i1 = i0 + SIDE_W'(fr != '0);
    end else begin
      d = p >> F;
      if (d > nm1) d = nm1;
      i0 = SIDE_W'(d);
      i1 = i0;
      fr = '0;
    end
    return {i0, i1, fr};
  endfunction

  assign ax_d = axis_f(pu2_q, width_i, mode_i == MODE_BILINEAR);
  assign ay_d = axis_f(pv2_q, height_i, mode_i == MODE_BILINEAR);

  assign fxe = CU_W'(fx_q);
  assign fye = CU_W'(fy_q);
  assign gx  = CU_W'(ONE_I) - fxe;
  assign gy  = CU_W'(ONE_I) - fye;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
      v3_q <= 1'b0;
      v4_q <= 1'b0;
    end else begin
      if (en1) v1_q <= in_valid_i;
      if (en2) v2_q <= v1_q;
      if (en3) v3_q <= v2_q;
      if (en4) v4_q <= v3_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en1) begin
      act1_q <= in_data_i.action;
      wa1_q  <= in_data_i.texel_address;
      wd1_q  <= {in_data_i.in_blue, in_data_i.in_green, in_data_i.in_red};
      u1_q   <= u_d;
      v1c_q  <= v_d;
    end
    if (en2) begin
      act2_q <= act1_q;
      wa2_q  <= wa1_q;
      wd2_q  <= wd1_q;
      pu2_q  <= PU_W'(u1_q) * PU_W'(width_i);
      pv2_q  <= PU_W'(v1c_q) * PU_W'(height_i);
    end
    if (en3) begin
      act3_q <= act2_q;
      wa3_q  <= wa2_q;
      wd3_q  <= wd2_q;
      {x0_q, x1_q, fx_q} <= ax_d;
      {y0_q, y1_q, fy_q} <= ay_d;
    end
    if (en4) begin
      act4_q <= act3_q;
      wa4_q  <= wa3_q;
      wd4_q  <= wd3_q;
      a_q[0] <= ADDR_W'(AP_W'(y0_q) * AP_W'(width_i) + AP_W'(x0_q));
      a_q[1] <= ADDR_W'(AP_W'(y0_q) * AP_W'(width_i) + AP_W'(x1_q));
      a_q[2] <= ADDR_W'(AP_W'(y1_q) * AP_W'(width_i) + AP_W'(x0_q));
      a_q[3] <= ADDR_W'(AP_W'(y1_q) * AP_W'(width_i) + AP_W'(x1_q));
      w_q[0] <= WW'(PW'(gx) * PW'(gy));
      w_q[1] <= WW'(PW'(fxe) * PW'(gy));
      w_q[2] <= WW'(PW'(gx) * PW'(fye));
      w_q[3] <= WW'(PW'(fxe) * PW'(fye));
    end
  end

  assign out_valid_o = v4_q;
  assign act_o       = act4_q;
  assign waddr_o     = wa4_q;
  assign wdata_o     = wd4_q;
  assign rd_addr_o   = a_q;
  assign weight_o    = w_q;

  a_nb_in_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (v3_q && act3_q == ACT_SAMPLE) |->
      (SZ_W'(x1_q) < width_i) && (SZ_W'(y1_q) < height_i))
    else $error("neighbor index beyond texture size");

  a_nearest_single: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (v3_q && act3_q == ACT_SAMPLE && mode_i == MODE_NEAREST) |->
      (x1_q == x0_q) && (y1_q == y0_q) && (fx_q == '0) && (fy_q == '0))
    else $error("nearest sample spans more than one texel");

  a_weight_sum: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (v4_q && act4_q == ACT_SAMPLE) |->
      ((WW + 2)'(w_q[0]) + (WW + 2)'(w_q[1]) + (WW + 2)'(w_q[2])
        + (WW + 2)'(w_q[3])) == W_ONE)
    else $error("blend weights do not sum to one");

endmodule
`default_nettype wire

FILE: rtl/tsb_texmem.sv
`default_nettype none
module tsb_texmem #(
  parameter int MAX_SIDE = 64,
  parameter int ADDR_W   = $clog2(MAX_SIDE * MAX_SIDE),
  parameter int WW       = 33
) (
  input  wire                                 clk_i,
  input  wire                                 rst_ni,
  input  wire                                 in_valid_i,
  output logic                                in_ready_o,
  input  wire                                 act_i,
  input  wire  [tsb_pkg::TADDR_W-1:0]         waddr_i,
  input  wire  [tsb_pkg::TEXEL_W-1:0]         wdata_i,
  input  wire  [3:0][ADDR_W-1:0]              rd_addr_i,
  input  wire  [3:0][WW-1:0]                  weight_i,
  output logic                                out_valid_o,
  input  wire                                 out_ready_i,
  output logic [3:0][tsb_pkg::TEXEL_W-1:0]    texel_o,
  output logic [3:0][WW-1:0]                  weight_o
);
  import tsb_pkg::*;

  localparam int DEPTH = MAX_SIDE * MAX_SIDE;

  logic en;
  logic v_q;
  logic we;
  logic [ADDR_W-1:0] widx;
  logic [3:0][WW-1:0] w_q;

  assign en         = !v_q || out_ready_i;
  assign in_ready_o = en;
  // addresses past the store are dropped
  assign we   = en && in_valid_i && (act_i == ACT_WRITE) && (32'(waddr_i) < DEPTH);
  assign widx = ADDR_W'(waddr_i);

  // one copy per neighbor so all four are read in the same cycle
  for (genvar k = 0; k < 4; k++) begin : g_bank
    logic [TEXEL_W-1:0] mem [DEPTH];
    logic [TEXEL_W-1:0] rd_q;
    always_ff @(posedge clk_i) begin
      if (we) mem[widx] <= wdata_i;
      if (en) rd_q <= mem[rd_addr_i[k]];
    end
    assign texel_o[k] = rd_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= 1'b0;
    end else if (en) begin
      v_q <= in_valid_i && (act_i == ACT_SAMPLE);
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) w_q <= weight_i;
  end

  assign out_valid_o = v_q;
  assign weight_o    = w_q;

endmodule
`default_nettype wire

FILE: rtl/tsb_blend.sv
`default_nettype none
module tsb_blend #(
  parameter int COORD_FRAC_BITS = 16,
  parameter int WW              = 2 * COORD_FRAC_BITS + 1
) (
  input  wire                                 clk_i,
  input  wire                                 rst_ni,
  input  wire                                 in_valid_i,
  output logic                                in_ready_o,
  input  wire  [3:0][tsb_pkg::TEXEL_W-1:0]    texel_i,
  input  wire  [3:0][WW-1:0]                  weight_i,
  output logic                                out_valid_o,
  input  wire                                 out_ready_i,
  output tsb_pkg::out_t                       out_data_o
);
  import tsb_pkg::*;

  localparam int F    = COORD_FRAC_BITS;
  localparam int PRW  = WW + CH_W;
  localparam int SW   = PRW + 2;
  localparam logic [SW-1:0] RND = SW'(1) << (2 * F - 1);

  logic en6, en7;
  logic v6_q, v7_q;
  logic [2:0][3:0][PRW-1:0] p_q;
  logic [2:0][CH_W-1:0]     ch_d, ch_q;

  assign en7 = !v7_q || out_ready_i;
  assign en6 = !v6_q || en7;
  assign in_ready_o = en6;

  always_comb begin
    logic [SW-1:0] s;
    logic [SW-1:0] r;
    for (int c = 0; c < 3; c++) begin
      s = SW'(p_q[c][0]) + SW'(p_q[c][1]) + SW'(p_q[c][2]) + SW'(p_q[c][3]) + RND;
      r = s >> (2 * F);
      ch_d[c] = (r > SW'(255)) ? 8'hff : r[CH_W-1:0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v6_q <= 1'b0;
      v7_q <= 1'b0;
    end else begin
      if (en6) v6_q <= in_valid_i;
      if (en7) v7_q <= v6_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en6) begin
      for (int c = 0; c < 3; c++) begin
        for (int k = 0; k < 4; k++) begin
          p_q[c][k] <= PRW'(texel_i[k][c*CH_W +: CH_W]) * PRW'(weight_i[k]);
        end
      end
    end
    if (en7) ch_q <= ch_d;
  end

  assign out_valid_o          = v7_q;
  assign out_data_o.out_red   = ch_q[0];
  assign out_data_o.out_green = ch_q[1];
  assign out_data_o.out_blue  = ch_q[2];

endmodule
`default_nettype wire

FILE: rtl/texture_sampler_bilinear.sv
// a sample passes the address, texel read and blend registers to reach out_o
// throughput: one request per cycle, writes and samples alike, while out_o is
//   ready, set by the four-copy store serving all four neighbor reads at once
// a write reaches the store after the address pipeline and produces no result
// reset clears the pipeline valids and sets width 64, height 64, nearest mode;
//   the texel store is not cleared
`default_nettype none
module texture_sampler_bilinear #(
  parameter int MAX_SIDE        = 64,
  parameter int COORD_FRAC_BITS = 16
) (
  input  wire        clk_i,
  input  wire        rst_ni,
  tsb_cfg_if.sink    cfg_i,
  tsb_in_if.sink     in_i,
  tsb_out_if.source  out_o
);
  import tsb_pkg::*;

  localparam int SZ_W     = $clog2(MAX_SIDE + 1);
  localparam int ADDR_W   = $clog2(MAX_SIDE * MAX_SIDE);
  localparam int WW       = 2 * COORD_FRAC_BITS + 1;
  localparam int RST_SIDE = (MAX_SIDE < 64) ? MAX_SIDE : 64;

  logic [SZ_W-1:0] width_q, height_q;
  logic            mode_q;
  logic [SZ_W-1:0] side_d;

  logic                      a_valid, a_ready, a_act;
  logic [TADDR_W-1:0]        a_waddr;
  logic [TEXEL_W-1:0]        a_wdata;
  logic [3:0][ADDR_W-1:0]    a_rd_addr;
  logic [3:0][WW-1:0]        a_weight;
  logic                      m_valid, m_ready;
  logic [3:0][TEXEL_W-1:0]   m_texel;
  logic [3:0][WW-1:0]        m_weight;

  assign cfg_i.ready = 1'b1;

  // size register saturates to 1..MAX_SIDE
  always_comb begin
    if (cfg_i.data == '0) side_d = SZ_W'(1);
    else if (32'(cfg_i.data) > MAX_SIDE) side_d = SZ_W'(MAX_SIDE);
    else side_d = SZ_W'(cfg_i.data);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      width_q  <= SZ_W'(RST_SIDE);
      height_q <= SZ_W'(RST_SIDE);
      mode_q   <= MODE_NEAREST;
    end else if (cfg_i.valid) begin
      unique case (cfg_i.index)
        CFG_TEX_WIDTH:   width_q  <= side_d;
        CFG_TEX_HEIGHT:  height_q <= side_d;
        CFG_FILTER_MODE: mode_q   <= cfg_i.data[0];
        default: ;
      endcase
    end
  end

  tsb_addr #(
    .MAX_SIDE        (MAX_SIDE),
    .COORD_FRAC_BITS (COORD_FRAC_BITS),
    .SZ_W            (SZ_W),
    .ADDR_W          (ADDR_W),
    .WW              (WW)
  ) u_addr (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .width_i     (width_q),
    .height_i    (height_q),
    .mode_i      (mode_q),
    .in_valid_i  (in_i.valid),
    .in_ready_o  (in_i.ready),
    .in_data_i   (in_i.data),
    .out_valid_o (a_valid),
    .out_ready_i (a_ready),
    .act_o       (a_act),
    .waddr_o     (a_waddr),
    .wdata_o     (a_wdata),
    .rd_addr_o   (a_rd_addr),
    .weight_o    (a_weight)
  );

  tsb_texmem #(
    .MAX_SIDE (MAX_SIDE),
    .ADDR_W   (ADDR_W),
    .WW       (WW)
  ) u_texmem (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (a_valid),
    .in_ready_o  (a_ready),
    .act_i       (a_act),
    .waddr_i     (a_waddr),
    .wdata_i     (a_wdata),
    .rd_addr_i   (a_rd_addr),
    .weight_i    (a_weight),
    .out_valid_o (m_valid),
    .out_ready_i (m_ready),
    .texel_o     (m_texel),
    .weight_o    (m_weight)
  );

  tsb_blend #(
    .COORD_FRAC_BITS (COORD_FRAC_BITS),
    .WW              (WW)
  ) u_blend (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (m_valid),
    .in_ready_o  (m_ready),
    .texel_i     (m_texel),
    .weight_i    (m_weight),
    .out_valid_o (out_o.valid),
    .out_ready_i (out_o.ready),
    .out_data_o  (out_o.data)
  );

endmodule
`default_nettype wire

FILE: tb/tsb_checker.sv
`default_nettype none
module tsb_checker
  import tsb_pkg::*;
(
  input  wire  clk_i,
  input  wire  rst_ni,
  tsb_cfg_if   cfg,
  tsb_in_if    req,
  tsb_out_if   res,
  output int   fails,
  output int   pending
);

  localparam longint FX_ONE  = 65536;
  localparam longint FX_HALF = 32768;

  logic [TEXEL_W-1:0] texels [4096];
  int                 tex_w;
  int                 tex_h;
  logic               filt;
  out_t               sample_q [$];

  assign pending = sample_q.size();

  function automatic int side_clamp(logic [CFG_DAT_W-1:0] d);
    if (d == 0) return 1;
    if (d > 64) return 64;
    return int'(d);
  endfunction

  function automatic longint unit_clamp(logic signed [COORD_W-1:0] c);
    longint x;
    x = longint'(c);
    if (x < 0) x = 0;
    if (x > FX_ONE) x = FX_ONE;
    return x;
  endfunction

  function automatic longint centre_clamp(longint c, int n);
    longint s;
    s = c * n - FX_HALF;
    if (s < 0) s = 0;
    if (s > (n - 1) * FX_ONE) s = (n - 1) * FX_ONE;
    return s;
  endfunction

  function automatic logic [TEXEL_W-1:0] texel_at(longint row, longint col);
    return texels[row * tex_w + col];
  endfunction

  function automatic out_t filtered_texel(in_t it);
    longint u, v, col, row, sx, sy, fx, fy, gx, gy, acc;
    longint x0, y0, x1, y1;
    logic [TEXEL_W-1:0] t00, t01, t10, t11, pix;
    out_t o;
    u = unit_clamp(it.coord_u);
    v = FX_ONE - unit_clamp(it.coord_v);
    if (filt == MODE_NEAREST) begin
      col = (u * tex_w) >>> 16;
      row = (v * tex_h) >>> 16;
      if (col > tex_w - 1) col = tex_w - 1;
      if (row > tex_h - 1) row = tex_h - 1;
      pix = texel_at(row, col);
    end else begin
      sx = centre_clamp(u, tex_w);
      sy = centre_clamp(v, tex_h);
      x0 = sx >>> 16;
      y0 = sy >>> 16;
      fx = sx & (FX_ONE - 1);
      fy = sy & (FX_ONE - 1);
      x1 = x0 + (fx != 0);
      y1 = y0 + (fy != 0);
      gx = FX_ONE - fx;
      gy = FX_ONE - fy;
      t00 = texel_at(y0, x0);
      t01 = texel_at(y0, x1);
      t10 = texel_at(y1, x0);
      t11 = texel_at(y1, x1);
      for (int ch = 0; ch < 3; ch++) begin
        acc = longint'(t00[8*ch +: 8]) * gx * gy + longint'(t01[8*ch +: 8]) * fx * gy
            + longint'(t10[8*ch +: 8]) * gx * fy + longint'(t11[8*ch +: 8]) * fx * fy;
        acc = (acc + (longint'(1) << 31)) >>> 32;
        if (acc > 255) acc = 255;
        pix[8*ch +: 8] = acc[7:0];
      end
    end
    // store packs red in the low byte
    o.out_red   = pix[7:0];
    o.out_green = pix[15:8];
    o.out_blue  = pix[23:16];
    return o;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    out_t exp_px;
    if (!rst_ni) begin
      tex_w = 64;
      tex_h = 64;
      filt  = MODE_NEAREST;
      fails = 0;
      sample_q.delete();
    end else begin
      if (cfg.valid && cfg.ready) begin
        case (cfg.index)
          CFG_TEX_WIDTH:   tex_w = side_clamp(cfg.data);
          CFG_TEX_HEIGHT:  tex_h = side_clamp(cfg.data);
          CFG_FILTER_MODE: filt  = cfg.data[0];
          default: ;
        endcase
      end
      if (res.valid && res.ready) begin
        if (sample_q.size() == 0) begin
          $display("%0t unexpected result: expected none, got %h", $time, res.data);
          fails++;
        end else begin
          exp_px = sample_q.pop_front();
          if (exp_px.out_red != res.data.out_red) begin
            $display("%0t red mismatch: expected %0d, got %0d", $time,
                     exp_px.out_red, res.data.out_red);
            fails++;
          end
          if (exp_px.out_green != res.data.out_green) begin
            $display("%0t green mismatch: expected %0d, got %0d", $time,
                     exp_px.out_green, res.data.out_green);
            fails++;
          end
          if (exp_px.out_blue != res.data.out_blue) begin
            $display("%0t blue mismatch: expected %0d, got %0d", $time,
                     exp_px.out_blue, res.data.out_blue);
            fails++;
          end
        end
      end
      if (req.valid && req.ready) begin
        if (req.data.action == ACT_WRITE)
          texels[req.data.texel_address] = {req.data.in_blue, req.data.in_green,
                                            req.data.in_red};
        else
          sample_q.push_back(filtered_texel(req.data));
      end
    end
  end

endmodule
`default_nettype wire

FILE: tb/texture_sampler_bilinear_tb.sv
`default_nettype none
module texture_sampler_bilinear_tb;
  import tsb_pkg::*;

  localparam int STALL_LIMIT = 5000;

  logic clk_i;
  logic rst_ni;
  logic calm;
  int   fails;
  int   pending;
  int   quiet_cycles = 0;

  tsb_cfg_if cfg_ch ();
  tsb_in_if  req_ch ();
  tsb_out_if res_ch ();

  texture_sampler_bilinear uut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .cfg_i  (cfg_ch),
    .in_i   (req_ch),
    .out_o  (res_ch)
  );

  tsb_checker chk (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .cfg     (cfg_ch),
    .req     (req_ch),
    .res     (res_ch),
    .fails   (fails),
    .pending (pending)
  );

  initial begin
    clk_i = 1'b0;
    forever #6 clk_i = ~clk_i;
  end

  always @(posedge clk_i) begin
    res_ch.ready <= calm ? 1'b1 : ($urandom_range(99) >= 11);
  end

  // watchdog: cycles with no request, result or register write
  always @(posedge clk_i) begin
    if ((req_ch.valid && req_ch.ready) || (res_ch.valid && res_ch.ready) ||
        (cfg_ch.valid && cfg_ch.ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= STALL_LIMIT) begin
      $display("TEST FAILED");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  task automatic send_req(in_t it);
    while (!calm && $urandom_range(99) < 11) begin
      req_ch.valid <= 1'b0;
      @(posedge clk_i);
    end
    req_ch.valid <= 1'b1;
    req_ch.data  <= it;
    @(posedge clk_i);
    while (!req_ch.ready) @(posedge clk_i);
  endtask

  task automatic drain;
    req_ch.valid <= 1'b0;
    @(posedge clk_i);
    while (pending != 0) @(posedge clk_i);
    // writes still in flight produce no result
    repeat (12) @(posedge clk_i);
  endtask

  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DAT_W-1:0] val);
    cfg_ch.valid <= 1'b1;
    cfg_ch.index <= idx;
    cfg_ch.data  <= val;
    @(posedge clk_i);
    while (!cfg_ch.ready) @(posedge clk_i);
    cfg_ch.valid <= 1'b0;
    @(posedge clk_i);
  endtask

  task automatic set_view(logic [CFG_DAT_W-1:0] w, logic [CFG_DAT_W-1:0] h, logic m);
    drain();
    write_reg(CFG_TEX_WIDTH, w);
    write_reg(CFG_TEX_HEIGHT, h);
    write_reg(CFG_FILTER_MODE, {6'd0, m});
  endtask

  function automatic logic signed [COORD_W-1:0] pick_coord();
    case ($urandom_range(9))
      0: return COORD_W'($urandom);
      1: begin
        case ($urandom_range(5))
          0: return 20'sd0;
          1: return 20'sd65536;
          2: return -20'sd1;
          3: return 20'sd65537;
          4: return -20'sd524288;
          default: return 20'sd524287;
        endcase
      end
      default: return COORD_W'($urandom_range(65536));
    endcase
  endfunction

  task automatic sample_at(logic signed [COORD_W-1:0] u, logic signed [COORD_W-1:0] v);
    in_t it;
    it = in_t'($urandom);
    it.action  = ACT_SAMPLE;
    it.coord_u = u;
    it.coord_v = v;
    send_req(it);
  endtask

  task automatic write_texel(logic [TADDR_W-1:0] addr);
    in_t it;
    it = in_t'({$urandom, $urandom, $urandom});
    it.action        = ACT_WRITE;
    it.texel_address = addr;
    send_req(it);
  endtask

  task automatic random_req;
    if ($urandom_range(99) < 20) write_texel(TADDR_W'($urandom));
    else sample_at(pick_coord(), pick_coord());
  endtask

  initial begin
    rst_ni       = 1'b0;
    calm         = 1'b0;
    req_ch.valid <= 1'b0;
    req_ch.data  <= '0;
    cfg_ch.valid <= 1'b0;
    cfg_ch.index <= CFG_TEX_WIDTH;
    cfg_ch.data  <= '0;
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // every entry a sample can reach holds data before anything is sampled:
    // random views stay within 32 by 32, the full-size samples below only
    // touch the low entries and the three written on top
    calm = 1'b1;
    for (int a = 0; a < 1024; a++) write_texel(TADDR_W'(a));
    write_texel(12'd2080);
    write_texel(12'd4032);
    write_texel(12'd4095);
    calm = 1'b0;

    // reset view, then the corners, the centre and far out-of-range coordinates
    sample_at(20'sd0, 20'sd0);
    sample_at(20'sd65536, 20'sd65536);
    sample_at(-20'sd524288, 20'sd524287);
    sample_at(20'sd524287, -20'sd524288);
    sample_at(20'sd32768, 20'sd32768);
    write_texel(12'd4095);
    sample_at(20'sd65536, 20'sd0);
    set_view(7'd64, 7'd64, MODE_BILINEAR);
    sample_at(20'sd0, 20'sd0);
    sample_at(20'sd65536, 20'sd65536);
    sample_at(20'sd512, 20'sd512);
    sample_at(20'sd33000, 20'sd65000);
    sample_at(-20'sd1, 20'sd65537);
    // zero size acts as one texel, oversize saturates
    set_view(7'd0, 7'd127, MODE_BILINEAR);
    sample_at(20'sd40000, 20'sd20000);
    sample_at(20'sd65536, 20'sd0);
    set_view(7'd1, 7'd1, MODE_NEAREST);
    sample_at(20'sd65536, 20'sd65536);
    sample_at(20'sd0, 20'sd0);
    set_view(7'd2, 7'd3, MODE_BILINEAR);
    // unknown register index must be ignored
    write_reg(2'd3, 7'h7f);
    sample_at(20'sd21845, 20'sd43690);
    sample_at(20'sd65536, 20'sd65536);

    for (int ph = 0; ph < 10; ph++) begin
      case (ph)
        0: set_view(7'd32, 7'd32, MODE_NEAREST);
        1: set_view(7'd1, 7'd64, MODE_BILINEAR);
        2: set_view(7'd64, 7'd1, MODE_NEAREST);
        3: set_view(7'd127, 7'd0, MODE_BILINEAR);
        default: set_view(CFG_DAT_W'($urandom_range(32)), CFG_DAT_W'($urandom_range(32)),
                          1'($urandom_range(1)));
      endcase
      calm = (ph == 5);
      for (int n = 0; n < 100; n++) random_req();
      calm = 1'b0;
    end

    drain();
    if (fails == 0) $display("TEST PASSED");
    else $display("TEST FAILED");
    $finish;
  end

endmodule
`default_nettype wire
